@@ hw/rtl/vhc_pkg.sv @@
package vhc_pkg;

   localparam int unsigned OPCODE_BITS   = 3;
   localparam int unsigned CAUSE_BITS    = 3;
   localparam int unsigned TICK_BITS     = 16;
   localparam int unsigned CSR_DATA_BITS = 16;
   localparam int unsigned CSR_INDEX_BITS = 2;

   typedef logic [OPCODE_BITS-1:0]    opcode_type;
   typedef logic [CAUSE_BITS-1:0]     cause_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam opcode_type OP_TICK     = 3'd0;
   localparam opcode_type OP_SAMPLE   = 3'd1;
   localparam opcode_type OP_OPEN     = 3'd2;
   localparam opcode_type OP_CLOSE    = 3'd3;
   localparam opcode_type OP_AUTO_ON  = 3'd4;
   localparam opcode_type OP_AUTO_OFF = 3'd5;

   localparam cause_type CAUSE_NONE      = 3'd0;
   localparam cause_type CAUSE_AUTO_LOW  = 3'd1;
   localparam cause_type CAUSE_AUTO_HIGH = 3'd2;
   localparam cause_type CAUSE_BUTTON    = 3'd3;
   localparam cause_type CAUSE_COMMAND   = 3'd4;

   localparam csr_index_type CSR_OPEN_BELOW     = 2'd0;
   localparam csr_index_type CSR_CLOSE_ABOVE    = 2'd1;
   localparam csr_index_type CSR_DEBOUNCE_TICKS = 2'd2;

   localparam logic [TICK_BITS-1:0] DEBOUNCE_RESET = 16'd50;

   typedef struct packed {
      logic valve;
      logic auto_mode;
      logic previous_level;
      logic stable_level;
   } flags_type;

   typedef struct packed {
      logic      valve_drive;
      logic      auto_on;
      logic      valve_changed;
      cause_type change_cause;
   } result_type;

endpackage

@@ hw/rtl/vhc_if.sv @@
interface vhc_req_if #(
   parameter int unsigned LEVEL_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic [2:0]            opcode;
   logic                  button_level;
   logic [LEVEL_BITS-1:0] water_level;

   modport source (output valid, output opcode, output button_level, output water_level,
                   input ready);
   modport sink (input valid, input opcode, input button_level, input water_level,
                 output ready);
endinterface

interface vhc_rsp_if;
   logic       valid;
   logic       ready;
   logic       valve_drive;
   logic       auto_on;
   logic       valve_changed;
   logic [2:0] change_cause;

   modport source (output valid, output valve_drive, output auto_on, output valve_changed,
                   output change_cause, input ready);
   modport sink (input valid, input valve_drive, input auto_on, input valve_changed,
                 input change_cause, output ready);
endinterface

@@ hw/rtl/vhc_csr.sv @@
module vhc_csr #(
   parameter int unsigned LEVEL_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  vhc_pkg::csr_index_type              csr_index,
   input  logic [vhc_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output logic [LEVEL_BITS-1:0]               open_below,
   output logic [LEVEL_BITS-1:0]               close_above,
   output logic [vhc_pkg::TICK_BITS-1:0]       debounce_ticks
);
   import vhc_pkg::*;

   logic [LEVEL_BITS-1:0] open_below_ff;
   logic [LEVEL_BITS-1:0] close_above_ff;
   logic [TICK_BITS-1:0]  debounce_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_below_ff     <= '0;
         close_above_ff    <= '1;
         debounce_ticks_ff <= DEBOUNCE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OPEN_BELOW: begin
               open_below_ff <= csr_wdata[LEVEL_BITS-1:0];
            end
            CSR_CLOSE_ABOVE: begin
               close_above_ff <= csr_wdata[LEVEL_BITS-1:0];
            end
            CSR_DEBOUNCE_TICKS: begin
               debounce_ticks_ff <= csr_wdata[TICK_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign open_below     = open_below_ff;
   assign close_above    = close_above_ff;
   assign debounce_ticks = debounce_ticks_ff;

endmodule

@@ hw/rtl/vhc_step.sv @@
module vhc_step #(
   parameter int unsigned LEVEL_BITS = 12,
   parameter int unsigned COUNT_BITS = 16
) (
   input  vhc_pkg::opcode_type                opcode,
   input  logic                               button_level,
   input  logic [LEVEL_BITS-1:0]              water_level,
   input  logic [LEVEL_BITS-1:0]              open_below,
   input  logic [LEVEL_BITS-1:0]              close_above,
   input  logic [vhc_pkg::TICK_BITS-1:0]      debounce_ticks,
   input  vhc_pkg::flags_type                 flags,
   input  logic [COUNT_BITS-1:0]              count,
   input  logic [LEVEL_BITS-1:0]              stored_water,
   output vhc_pkg::flags_type                 flags_in,
   output logic [COUNT_BITS-1:0]              count_in,
   output logic [LEVEL_BITS-1:0]              stored_water_in,
   output vhc_pkg::result_type                result
);
   import vhc_pkg::*;

   localparam int unsigned CMP_BITS = (COUNT_BITS > TICK_BITS) ? COUNT_BITS : TICK_BITS;

   logic                  drive_en;
   logic                  drive_val;
   cause_type             drive_cause;
   logic                  hyst_en;
   logic [LEVEL_BITS-1:0] hyst_level;
   logic                  changed;

   always_comb begin
      flags_in        = flags;
      count_in        = count;
      stored_water_in = stored_water;
      drive_en        = 1'b0;
      drive_val       = 1'b0;
      drive_cause     = CAUSE_NONE;
      hyst_en         = 1'b0;
      hyst_level      = stored_water;

      case (opcode)
         OP_TICK: begin
            if (button_level != flags.previous_level) begin
               count_in = '0;
            end else if (count != '1) begin
               count_in = count + COUNT_BITS'(1);
            end
            flags_in.previous_level = button_level;
            if ((CMP_BITS'(count_in) > CMP_BITS'(debounce_ticks))
                && (button_level != flags.stable_level)) begin
               flags_in.stable_level = button_level;
               if (!button_level) begin
                  flags_in.auto_mode = 1'b0;
                  drive_en           = 1'b1;
                  drive_val          = !flags.valve;
                  drive_cause        = CAUSE_BUTTON;
               end
            end
         end
         OP_SAMPLE: begin
            stored_water_in = water_level;
            hyst_en         = flags.auto_mode;
            hyst_level      = water_level;
         end
         OP_OPEN: begin
            flags_in.auto_mode = 1'b0;
            drive_en           = 1'b1;
            drive_val          = 1'b1;
            drive_cause        = CAUSE_COMMAND;
         end
         OP_CLOSE: begin
            flags_in.auto_mode = 1'b0;
            drive_en           = 1'b1;
            drive_val          = 1'b0;
            drive_cause        = CAUSE_COMMAND;
         end
         OP_AUTO_ON: begin
            flags_in.auto_mode = 1'b1;
            hyst_en            = 1'b1;
         end
         OP_AUTO_OFF: begin
            flags_in.auto_mode = 1'b0;
         end
         default: begin
         end
      endcase

      // opening wins when the thresholds overlap
      if (hyst_en) begin
         if (hyst_level < open_below) begin
            drive_en    = 1'b1;
            drive_val   = 1'b1;
            drive_cause = CAUSE_AUTO_LOW;
         end else if (hyst_level > close_above) begin
            drive_en    = 1'b1;
            drive_val   = 1'b0;
            drive_cause = CAUSE_AUTO_HIGH;
         end
      end

      changed = drive_en && (drive_val != flags.valve);
      if (changed) begin
         flags_in.valve = drive_val;
      end

      result.valve_drive   = flags_in.valve;
      result.auto_on       = flags_in.auto_mode;
      result.valve_changed = changed;
      result.change_cause  = changed ? drive_cause : CAUSE_NONE;
   end

endmodule

@@ hw/rtl/valve_hysteresis_controller_core.sv @@
// Pipeline: an accepted item is held in the item register, then its result in the result
// register; a response that is not taken stalls both.
// Throughput: one item per cycle while each response is taken; the state update between
// the item register and the result register sets that rate.
// Reset: synchronous, active high; clears valve, auto mode, debounce count, stored
// sample and both valid flags, sets the debounce levels high, loads register defaults.
module valve_hysteresis_controller_core #(
   parameter int unsigned LEVEL_BITS = 12,
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   vhc_req_if.sink                            req,
   vhc_rsp_if.source                          rsp,
   input  logic                               csr_we,
   input  vhc_pkg::csr_index_type             csr_index,
   input  logic [vhc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import vhc_pkg::*;

   logic [LEVEL_BITS-1:0] open_below;
   logic [LEVEL_BITS-1:0] close_above;
   logic [TICK_BITS-1:0]  debounce_ticks;

   logic                  item_valid_ff;
   opcode_type            item_opcode_ff;
   logic                  item_button_ff;
   logic [LEVEL_BITS-1:0] item_water_ff;

   flags_type             flags_ff;
   flags_type             flags_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [LEVEL_BITS-1:0] stored_water_ff;
   logic [LEVEL_BITS-1:0] stored_water_in;

   result_type            result_ff;
   result_type            result_in;
   logic                  rsp_valid_ff;

   logic                  advance;
   logic                  take;

   vhc_csr #(
      .LEVEL_BITS (LEVEL_BITS)
   ) u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .open_below     (open_below),
      .close_above    (close_above),
      .debounce_ticks (debounce_ticks)
   );

   vhc_step #(
      .LEVEL_BITS (LEVEL_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .opcode          (item_opcode_ff),
      .button_level    (item_button_ff),
      .water_level     (item_water_ff),
      .open_below      (open_below),
      .close_above     (close_above),
      .debounce_ticks  (debounce_ticks),
      .flags           (flags_ff),
      .count           (count_ff),
      .stored_water    (stored_water_ff),
      .flags_in        (flags_in),
      .count_in        (count_in),
      .stored_water_in (stored_water_in),
      .result          (result_in)
   );

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !item_valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req.ready) begin
         item_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_opcode_ff <= req.opcode;
         item_button_ff <= req.button_level;
         item_water_ff  <= req.water_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff        <= '{valve: 1'b0, auto_mode: 1'b0,
                              previous_level: 1'b1, stable_level: 1'b1};
         count_ff        <= '0;
         stored_water_ff <= '0;
      end else if (advance) begin
         flags_ff        <= flags_in;
         count_ff        <= count_in;
         stored_water_ff <= stored_water_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.valve_drive   = result_ff.valve_drive;
   assign rsp.auto_on       = result_ff.auto_on;
   assign rsp.valve_changed = result_ff.valve_changed;
   assign rsp.change_cause  = result_ff.change_cause;

`ifndef SYNTHESIS
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> (flags_ff == $past(flags_ff)) && (count_ff == $past(count_ff)))
      else $error("state moved without an item");

   a_change_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (result_ff.valve_changed == (result_ff.change_cause != CAUSE_NONE)))
      else $error("change flag and cause disagree");

   a_auto_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((result_ff.change_cause == CAUSE_AUTO_LOW)
                       || (result_ff.change_cause == CAUSE_AUTO_HIGH))
      |-> result_ff.auto_on)
      else $error("auto change with auto off");

   a_manual_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((result_ff.change_cause == CAUSE_BUTTON)
                       || (result_ff.change_cause == CAUSE_COMMAND))
      |-> !result_ff.auto_on)
      else $error("manual change left auto on");
`endif

endmodule
